// ----- rtl/hatd_pkg.sv -----
// ----------------------------------------------------------------------------
// hatd_pkg
// shared types, constants and helper functions of the hex array text decoder
// ----------------------------------------------------------------------------
package hatd_pkg;

  localparam int unsigned CMD_QUEUE_DEPTH = 4;
  localparam int unsigned NAME_LEN        = 7;

  localparam logic [7:0] CH_OPEN  = 8'h7B;  // '{'
  localparam logic [7:0] CH_CLOSE = 8'h7D;  // '}'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_X_LO  = 8'h78;  // 'x'
  localparam logic [7:0] CH_X_UP  = 8'h58;  // 'X'
  localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'
  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef enum logic [2:0] {
    PH_NAME = 3'd0,
    PH_OPEN = 3'd1,
    PH_SCAN = 3'd2,
    PH_ZERO = 3'd3,
    PH_HEX1 = 3'd4,
    PH_HEX2 = 3'd5,
    PH_DONE = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_report;
    logic       close_found;
    logic       result_last;
  } out_item_t;

  // work left for the back end by one character
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       has_report;
    logic       close_found;
  } cmd_t;

  // characters of "_data[]"
  function automatic logic [7:0] name_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h5F;  // '_'
      3'd1:    ch = 8'h64;  // 'd'
      3'd2:    ch = 8'h61;  // 'a'
      3'd3:    ch = 8'h74;  // 't'
      3'd4:    ch = 8'h61;  // 'a'
      3'd5:    ch = 8'h5B;  // '['
      3'd6:    ch = 8'h5D;  // ']'
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // hex digit value, HEX_NONE when not a digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = 5'd9 + {2'b00, c[2:0]};
    end else begin
      v = HEX_NONE;
    end
    return v;
  endfunction

  // phase after a character seen while scanning
  function automatic phase_t scan_phase(input logic [7:0] c);
    phase_t p;
    if (c == CH_CLOSE) begin
      p = PH_DONE;
    end else if (c == CH_ZERO) begin
      p = PH_ZERO;
    end else begin
      p = PH_SCAN;
    end
    return p;
  endfunction

endpackage

// ----- rtl/hex_array_text_decoder.sv -----
// ----------------------------------------------------------------------------
// hex_array_text_decoder
// recovers the bytes of a hex array from header text, one character a cycle
// ----------------------------------------------------------------------------
// The block takes one text character per clock. It looks for the first
// "_data[]", then the next '{', and from there up to the first '}' decodes
// every 0x/0X token with two hex digits into one data result. A character
// marked last also yields a report result whose close_found flag says whether
// the closing brace was seen; bytes are only valid if that flag is 1. The
// parser front end accepts a character on every cycle in which full is low;
// full rises only when the command queue (DEPTH entries) is backed up by a
// stalled consumer. While the consumer pops every cycle, the result stage
// emits one result per cycle; a last character that also completes a byte
// yields a data result followed by a report result. A result passes through
// the command queue and the output register to reach the result port.
// ----------------------------------------------------------------------------
module hex_array_text_decoder
  import hatd_pkg::*;
#(
  parameter int unsigned DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  // character side
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  // result side
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  // parser to queue
  logic q_wr;
  cmd_t q_wr_cmd;
  logic q_full;

  // queue to result stage
  logic q_rd;
  cmd_t q_rd_cmd;
  logic q_empty;

  assign full = q_full;

  // front end: name/brace/token tracking, one character per transaction
  hatd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_cmd  (q_wr_cmd)
  );

  // decouples the parser from a stalled consumer
  hatd_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_cmd),
    .rd      (q_rd),
    .rd_data (q_rd_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back end: byte and report results through an output register
  hatd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (q_rd_cmd),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ----- rtl/hatd_front.sv -----
// ----------------------------------------------------------------------------
// hatd_front
// character parser: tracks the name, brace and token state, issues commands
// ----------------------------------------------------------------------------
module hatd_front
  import hatd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t item,
  input  logic     q_full,
  output logic     q_wr,
  output cmd_t     q_cmd
);

  phase_t     phase, phase_next;
  logic [2:0] name_match_count, name_match_count_next;
  logic [3:0] high_nibble, high_nibble_next;
  phase_t     ph_c;
  logic [2:0] cnt_c;
  logic [3:0] hn_c;
  logic       byte_ok;
  logic [7:0] byte_val;
  logic [4:0] hv;
  logic [2:0] idx;
  logic [7:0] c;
  logic       accept;

  assign c      = item.text_char;
  assign accept = push && !q_full;
  assign hv     = hex_value(c);

  always_comb begin
    ph_c     = phase;
    cnt_c    = name_match_count;
    hn_c     = high_nibble;
    byte_ok  = 1'b0;
    byte_val = {high_nibble, hv[3:0]};
    idx      = (name_match_count >= 3'(NAME_LEN)) ? 3'd0 : name_match_count;
    case (phase)
      PH_OPEN: begin
        if (c == CH_OPEN) ph_c = PH_SCAN;
      end
      PH_SCAN: begin
        ph_c = scan_phase(c);
      end
      PH_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) ph_c = PH_HEX1;
        else ph_c = scan_phase(c);
      end
      PH_HEX1: begin
        if (hv != HEX_NONE) begin
          hn_c = hv[3:0];
          ph_c = PH_HEX2;
        end else begin
          ph_c = scan_phase(c);
        end
      end
      PH_HEX2: begin
        if (hv != HEX_NONE) begin
          byte_ok = 1'b1;
          ph_c    = PH_SCAN;
        end else begin
          ph_c = scan_phase(c);
        end
      end
      PH_DONE: begin
        ph_c = PH_DONE;
      end
      default: begin
        ph_c = PH_NAME;
        if (c == name_char(idx)) begin
          if (idx == 3'(NAME_LEN - 1)) begin
            cnt_c = 3'd0;
            ph_c  = PH_OPEN;
          end else begin
            cnt_c = idx + 3'd1;
          end
        end else begin
          cnt_c = (c == CH_UNDER) ? 3'd1 : 3'd0;
        end
      end
    endcase

    // end of text: back to the start state for the next text
    if (item.last_char) begin
      phase_next            = PH_NAME;
      name_match_count_next = 3'd0;
      high_nibble_next      = 4'd0;
    end else begin
      phase_next            = ph_c;
      name_match_count_next = cnt_c;
      high_nibble_next      = hn_c;
    end

    q_cmd.has_byte    = byte_ok;
    q_cmd.data_byte   = byte_val;
    q_cmd.has_report  = item.last_char;
    q_cmd.close_found = (ph_c == PH_DONE);
    q_wr              = accept && (byte_ok || item.last_char);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_NAME;
      name_match_count <= 3'd0;
      high_nibble      <= 4'd0;
    end else if (accept) begin
      phase            <= phase_next;
      name_match_count <= name_match_count_next;
      high_nibble      <= high_nibble_next;
    end
  end

endmodule

// ----- rtl/hatd_fifo.sv -----
// ----------------------------------------------------------------------------
// hatd_fifo
// short command queue between the parser and the result stage
// ----------------------------------------------------------------------------
module hatd_fifo
  import hatd_pkg::*;
#(
  parameter int unsigned DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  input  logic rd,
  output cmd_t rd_data,
  output logic full,
  output logic empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_wr_grows: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue count not advanced on write");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers out of step with count");
`endif

endmodule

// ----- rtl/hatd_back.sv -----
// ----------------------------------------------------------------------------
// hatd_back
// result stage: expands queued commands into one or two result items
// ----------------------------------------------------------------------------
module hatd_back
  import hatd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      q_cmd,
  input  logic      q_empty,
  output logic      q_rd,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  logic      out_valid;
  out_item_t out_reg;
  logic      rep_pend;
  logic      rep_close;
  logic      load;

  assign empty  = !out_valid;
  assign result = out_reg;
  assign load   = !out_valid || pop;
  assign q_rd   = load && !rep_pend && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rep_pend  <= 1'b0;
    end else if (load) begin
      if (rep_pend) begin
        out_valid <= 1'b1;
        rep_pend  <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        rep_pend  <= q_cmd.has_byte && q_cmd.has_report;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (rep_pend) begin
        out_reg <= '{data_byte: 8'h00, is_report: 1'b1, close_found: rep_close,
                     result_last: 1'b1};
      end else if (q_cmd.has_byte) begin
        out_reg <= '{data_byte: q_cmd.data_byte, is_report: 1'b0, close_found: 1'b0,
                     result_last: !q_cmd.has_report};
      end else begin
        out_reg <= '{data_byte: 8'h00, is_report: 1'b1,
                     close_found: q_cmd.close_found, result_last: 1'b1};
      end
      if (!rep_pend) rep_close <= q_cmd.close_found;
    end
  end

`ifndef SYNTHESIS
  a_report_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.is_report) |-> (out_reg.data_byte == 8'h00 && out_reg.result_last))
    else $error("report item with data or without last mark");
  a_byte_no_close: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.is_report) |-> !out_reg.close_found)
    else $error("data item carries close flag");
  a_pend_held: assert property (@(posedge clk) disable iff (rst)
    rep_pend |-> (out_valid && !out_reg.is_report && !out_reg.result_last))
    else $error("pending report without its data byte in front");
`endif

endmodule
